/* sv/atan2fta_pkg.sv */
// Shared types and constants for the four-term atan2 unit.
// Pipeline depth, field widths, register indexes and register reset values.
// No dependencies.
package atan2fta_pkg;

    // pipeline shape: one preparation stage, the divider, then the polynomial
    localparam int DIV_STAGES   = 8;
    localparam int DIV_BITS     = 2;   // quotient bits retired per divider stage
    localparam int NSTG         = 16;  // total register stages, output included
    localparam int STG_R2       = DIV_STAGES + 1;
    localparam int STG_H1       = DIV_STAGES + 2;
    localparam int STG_H2       = DIV_STAGES + 3;
    localparam int STG_H3       = DIV_STAGES + 4;
    localparam int STG_P        = DIV_STAGES + 5;
    localparam int STG_OCT      = DIV_STAGES + 6;
    localparam int STG_OUT      = DIV_STAGES + 7;

    localparam int COORD_W      = 16;
    localparam int COEF_W       = 18;
    localparam int QTURN_W      = 14;
    localparam int HTURN_W      = 15;
    localparam int CFG_IDX_W    = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_FIRST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_THIRD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_FIFTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_SEVENTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_QUARTER_TURN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_TURN    = 3'd5;

    // register reset values
    localparam logic signed [COEF_W-1:0] RST_COEF_FIRST   = 18'sd65527;
    localparam logic signed [COEF_W-1:0] RST_COEF_THIRD   = -18'sd21647;
    localparam logic signed [COEF_W-1:0] RST_COEF_FIFTH   = 18'sd11806;
    localparam logic signed [COEF_W-1:0] RST_COEF_SEVENTH = -18'sd5579;
    localparam logic [QTURN_W-1:0]       RST_QUARTER_TURN = 14'd12868;
    localparam logic [HTURN_W-1:0]       RST_HALF_TURN    = 15'd25736;

    localparam logic signed [COORD_W-1:0] ANGLE_MAX = 16'sd32767;
    localparam logic signed [COORD_W-1:0] ANGLE_MIN = -16'sd32767;

    // per-word side information that rides along every stage
    typedef struct packed {
        logic zero;     // both coordinates zero
        logic eq;       // equal magnitudes, ratio pinned to all ones
        logic x_major;  // |x| > |y|
        logic y_neg;
        logic x_neg;
    } meta_t;

endpackage

/* sv/atan2_four_term_approx_unit.sv */
// Top level of the four-term atan2 unit: divider, odd polynomial, octant and
// quadrant folding in one sixteen-stage pipeline.
// Depends on atan2fta_pkg.
//
//  channel   direction  ports                                   handshake
//  s_        in         s_y_coord, s_x_coord                    s_valid / s_ready
//  m_        out        m_angle, m_zero_vector                  m_valid / m_ready
//  cfg_      in         cfg_index, cfg_data                     cfg_valid / cfg_ready
//
// One word enters per cycle unless every stage is full and the output held.
// It holds one preparation stage, the 8-stage restoring divider (two quotient
// bits each), one squaring, four Horner/product multiplier and two folding stages.
// aresetn is synchronous, active low; it empties the pipeline and restores
// the register defaults. Each stage moves when it is empty or the stage after
// it moves, so bubbles close up and a stalled output holds without loss.
module atan2_four_term_approx_unit (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [atan2fta_pkg::COORD_W-1:0] s_y_coord,
    input  logic signed [atan2fta_pkg::COORD_W-1:0] s_x_coord,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [atan2fta_pkg::COORD_W-1:0] m_angle,
    output logic                                    m_zero_vector,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [atan2fta_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [atan2fta_pkg::COEF_W-1:0]         cfg_data
);

    localparam int NSTG = atan2fta_pkg::NSTG;
    localparam int NDIV = atan2fta_pkg::DIV_STAGES;
    localparam int CW   = atan2fta_pkg::COORD_W;

    // configuration registers
    logic signed [atan2fta_pkg::COEF_W-1:0] coef_first_reg;
    logic signed [atan2fta_pkg::COEF_W-1:0] coef_third_reg;
    logic signed [atan2fta_pkg::COEF_W-1:0] coef_fifth_reg;
    logic signed [atan2fta_pkg::COEF_W-1:0] coef_seventh_reg;
    logic [atan2fta_pkg::QTURN_W-1:0]       quarter_turn_reg;
    logic [atan2fta_pkg::HTURN_W-1:0]       half_turn_reg;

    // pipeline control
    logic [NSTG-1:0]     valid_reg;
    logic [NSTG-1:0]     load;
    atan2fta_pkg::meta_t meta_reg [NSTG];
    atan2fta_pkg::meta_t meta_in;
    logic [CW-1:0]       small_mag;
    logic [CW-1:0]       big_mag;

    // divider stages; index 0 is the preparation stage
    logic [CW-1:0] div_rem_reg  [NDIV+1];
    logic [CW-1:0] div_big_reg  [NDIV+1];
    logic [CW-1:0] div_quo_reg  [NDIV+1];
    logic [CW-1:0] div_rem_next [NDIV+1];
    logic [CW-1:0] div_big_next [NDIV+1];
    logic [CW-1:0] div_quo_next [NDIV+1];

    // polynomial stages
    logic [CW-1:0]        r9_reg,  r2_9_reg;
    logic [CW-1:0]        r10_reg, r2_10_reg;
    logic [CW-1:0]        r11_reg, r2_11_reg;
    logic [CW-1:0]        r12_reg;
    logic signed [19:0]   acc10_reg;
    logic signed [21:0]   acc11_reg;
    logic signed [23:0]   acc12_reg;
    logic signed [24:0]   p13_reg;
    logic signed [23:0]   a14_reg;
    logic signed [CW-1:0] angle_reg;
    logic                 zero_reg;

    logic [CW-1:0]        r9_next, r2_9_next;
    logic [2*CW-1:0]      rr9;
    logic signed [34:0]   prod10;
    logic signed [18:0]   sh10;
    logic signed [19:0]   acc10_next;
    logic signed [36:0]   prod11;
    logic signed [20:0]   sh11;
    logic signed [21:0]   acc11_next;
    logic signed [38:0]   prod12;
    logic signed [22:0]   sh12;
    logic signed [23:0]   acc12_next;
    logic signed [40:0]   prod13;
    logic signed [24:0]   p13_next;
    logic signed [25:0]   p_rnd;
    logic signed [22:0]   a_oct;
    logic signed [23:0]   a14_next;
    logic signed [24:0]   ang_full;
    logic signed [CW-1:0] angle_next;

    // configuration port: always ready, unknown indexes dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_first_reg   <= atan2fta_pkg::RST_COEF_FIRST;
            coef_third_reg   <= atan2fta_pkg::RST_COEF_THIRD;
            coef_fifth_reg   <= atan2fta_pkg::RST_COEF_FIFTH;
            coef_seventh_reg <= atan2fta_pkg::RST_COEF_SEVENTH;
            quarter_turn_reg <= atan2fta_pkg::RST_QUARTER_TURN;
            half_turn_reg    <= atan2fta_pkg::RST_HALF_TURN;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                atan2fta_pkg::REG_COEF_FIRST:   coef_first_reg   <= $signed(cfg_data);
                atan2fta_pkg::REG_COEF_THIRD:   coef_third_reg   <= $signed(cfg_data);
                atan2fta_pkg::REG_COEF_FIFTH:   coef_fifth_reg   <= $signed(cfg_data);
                atan2fta_pkg::REG_COEF_SEVENTH: coef_seventh_reg <= $signed(cfg_data);
                atan2fta_pkg::REG_QUARTER_TURN:
                    quarter_turn_reg <= cfg_data[atan2fta_pkg::QTURN_W-1:0];
                atan2fta_pkg::REG_HALF_TURN:
                    half_turn_reg <= cfg_data[atan2fta_pkg::HTURN_W-1:0];
                default: ;
            endcase
        end
    end

    // stage advance: a stage loads when empty or when its successor loads
    always_comb begin
        load[NSTG-1] = !valid_reg[NSTG-1] || m_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    assign s_ready = load[0];
    assign m_valid = valid_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (load[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (load[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // preparation: magnitudes, octant and the special cases
    always_comb begin
        logic [CW-1:0] ay;
        logic [CW-1:0] ax;
        ay = s_y_coord[CW-1] ? (~s_y_coord) + 1'b1 : s_y_coord;
        ax = s_x_coord[CW-1] ? (~s_x_coord) + 1'b1 : s_x_coord;
        meta_in.x_major = ax > ay;
        small_mag       = meta_in.x_major ? ay : ax;
        big_mag         = meta_in.x_major ? ax : ay;
        meta_in.zero    = big_mag == '0;
        meta_in.eq      = small_mag == big_mag;
        meta_in.y_neg   = s_y_coord[CW-1];
        meta_in.x_neg   = s_x_coord[CW-1];
    end

    // divider: take the prepared operands, then restoring steps,
    // two quotient bits per stage
    always_comb begin
        logic [CW-1:0] rem;
        logic [CW-1:0] quo;
        logic [CW:0]   sh;
        div_rem_next[0] = small_mag;
        div_big_next[0] = big_mag;
        div_quo_next[0] = '0;
        for (int k = 1; k <= NDIV; k++) begin
            rem = div_rem_reg[k-1];
            quo = div_quo_reg[k-1];
            for (int j = 0; j < atan2fta_pkg::DIV_BITS; j++) begin
                sh = {rem, 1'b0};
                if (sh >= {1'b0, div_big_reg[k-1]}) begin
                    sh  = sh - {1'b0, div_big_reg[k-1]};
                    quo = {quo[CW-2:0], 1'b1};
                end else begin
                    quo = {quo[CW-2:0], 1'b0};
                end
                rem = sh[CW-1:0];
            end
            div_rem_next[k] = rem;
            div_big_next[k] = div_big_reg[k-1];
            div_quo_next[k] = quo;
        end
    end

    // ratio square, Horner steps and the final product
    always_comb begin
        r9_next    = meta_reg[NDIV].eq ? '1 : div_quo_reg[NDIV];
        rr9        = r9_next * r9_next;
        r2_9_next  = rr9[2*CW-1:CW];

        prod10     = coef_seventh_reg * $signed({1'b0, r2_9_reg});
        sh10       = 19'(prod10 >>> 16);
        acc10_next = 20'(sh10) + 20'(coef_fifth_reg);

        prod11     = acc10_reg * $signed({1'b0, r2_10_reg});
        sh11       = 21'(prod11 >>> 16);
        acc11_next = 22'(sh11) + 22'(coef_third_reg);

        prod12     = acc11_reg * $signed({1'b0, r2_11_reg});
        sh12       = 23'(prod12 >>> 16);
        acc12_next = 24'(sh12) + 24'(coef_first_reg);

        prod13     = acc12_reg * $signed({1'b0, r12_reg});
        p13_next   = 25'(prod13 >>> 16);
    end

    // round to Q3.13 and fold the octant
    always_comb begin
        p_rnd = 26'(p13_reg) + 26'sd4;
        a_oct = 23'(p_rnd >>> 3);
        if (meta_reg[atan2fta_pkg::STG_P].x_major) begin
            a14_next = 24'(a_oct);
        end else begin
            a14_next = $signed({10'd0, quarter_turn_reg}) - 24'(a_oct);
        end
    end

    // mirror into the quadrant and saturate
    always_comb begin
        unique case ({meta_reg[atan2fta_pkg::STG_OCT].y_neg,
                      meta_reg[atan2fta_pkg::STG_OCT].x_neg})
            2'b00:   ang_full = 25'(a14_reg);
            2'b10:   ang_full = -25'(a14_reg);
            2'b01:   ang_full = $signed({10'd0, half_turn_reg}) - 25'(a14_reg);
            default: ang_full = 25'(a14_reg) - $signed({10'd0, half_turn_reg});
        endcase
        if (meta_reg[atan2fta_pkg::STG_OCT].zero) begin
            angle_next = '0;
        end else if (ang_full > 25'(atan2fta_pkg::ANGLE_MAX)) begin
            angle_next = atan2fta_pkg::ANGLE_MAX;
        end else if (ang_full < 25'(atan2fta_pkg::ANGLE_MIN)) begin
            angle_next = atan2fta_pkg::ANGLE_MIN;
        end else begin
            angle_next = ang_full[CW-1:0];
        end
    end

    // payload registers, each loaded with its stage
    always_ff @(posedge aclk) begin
        if (load[0]) begin
            meta_reg[0] <= meta_in;
        end
        for (int i = 1; i < NSTG; i++) begin
            if (load[i]) begin
                meta_reg[i] <= meta_reg[i-1];
            end
        end
        for (int k = 0; k <= NDIV; k++) begin
            if (load[k]) begin
                div_rem_reg[k] <= div_rem_next[k];
                div_big_reg[k] <= div_big_next[k];
                div_quo_reg[k] <= div_quo_next[k];
            end
        end
        if (load[atan2fta_pkg::STG_R2]) begin
            r9_reg   <= r9_next;
            r2_9_reg <= r2_9_next;
        end
        if (load[atan2fta_pkg::STG_H1]) begin
            acc10_reg <= acc10_next;
            r10_reg   <= r9_reg;
            r2_10_reg <= r2_9_reg;
        end
        if (load[atan2fta_pkg::STG_H2]) begin
            acc11_reg <= acc11_next;
            r11_reg   <= r10_reg;
            r2_11_reg <= r2_10_reg;
        end
        if (load[atan2fta_pkg::STG_H3]) begin
            acc12_reg <= acc12_next;
            r12_reg   <= r11_reg;
        end
        if (load[atan2fta_pkg::STG_P]) begin
            p13_reg <= p13_next;
        end
        if (load[atan2fta_pkg::STG_OCT]) begin
            a14_reg <= a14_next;
        end
        if (load[atan2fta_pkg::STG_OUT]) begin
            angle_reg <= angle_next;
            zero_reg  <= meta_reg[atan2fta_pkg::STG_OCT].zero;
        end
    end

    assign m_angle       = angle_reg;
    assign m_zero_vector = zero_reg;

`ifndef SYNTHESIS
    // a zero vector always reports angle zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_vector |-> m_angle == '0)
        else $error("zero vector word with nonzero angle");

    // input stalls only when every stage is full and the output is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready && (&valid_reg))
        else $error("input stalled with room in the pipeline");

    // saturation keeps the most negative code out
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_angle != atan2fta_pkg::ANGLE_MIN - 16'sd1)
        else $error("angle outside the saturated range");
`endif

endmodule
